FILE: rtl/scbr_pkg.sv
package scbr_pkg;

	localparam int MAX_NODES  = 64;
	localparam int COUNT_W    = 32;
	localparam int NODE_W     = 6;
	localparam int NODE_AW    = $clog2(MAX_NODES);
	localparam int CNT_W      = NODE_AW + 1;
	localparam int REQ_W      = 8;
	localparam int STEP_W     = 8;
	localparam int STATUS_W   = 2;
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);

	typedef enum logic [STATUS_W-1:0] {
		STAT_REPLY = 2'd0,
		STAT_ZERO  = 2'd1,
		STAT_OVFL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REL
	} state_t;

	typedef struct packed {
		logic               en;
		logic [NODE_AW-1:0] addr;
		logic [NODE_W-1:0]  data;
	} list_wr_t;

	typedef struct packed {
		logic               en;
		logic [NODE_AW-1:0] addr;
	} list_rd_t;

endpackage

FILE: rtl/shared_counter_barrier_release_top.sv
// Fetch-and-add counter with barrier release. A request is taken when start is high and busy is
// low; busy then stays high until the block can take the next one. Zero, positive, overflow and
// plain append requests are captured, then finish in one pass through the shared adder; a
// positive request answers with the counter and then adds step. A release of n listed nodes reads
// the done list, a memory with one write and one read port, one entry per cycle, newest first.
// Each result word is on the outputs for exactly one cycle with strobe high; the receiver cannot
// stall, so it must take every strobed word. The last word caused by a request has last set.
// step_we writes step; the user must do so only while idle, which the block does not enforce.
module shared_counter_barrier_release_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [scbr_pkg::NODE_W-1:0]   node_id,
	input  logic signed [scbr_pkg::REQ_W-1:0] request_value,
	input  logic                          step_we,
	input  logic [scbr_pkg::STEP_W-1:0]   step_data,
	output logic                          strobe,
	output logic [scbr_pkg::NODE_W-1:0]   dest_node,
	output logic [scbr_pkg::COUNT_W-1:0]  count_value,
	output logic [scbr_pkg::STATUS_W-1:0] status,
	output logic                          last
);
	import scbr_pkg::*;

	state_t state_q, state_d;

	logic [STEP_W-1:0]  step_q;
	logic [COUNT_W-1:0] counter_q;
	logic [CNT_W-1:0]   done_count_q;
	logic [NODE_W-1:0]  node_q;
	logic [REQ_W-1:0]   req_q;

	logic               strobe_q, from_mem_q, last_q;
	logic [NODE_W-1:0]  dest_q;
	logic [COUNT_W-1:0] count_q;
	status_t            status_q;

	logic [COUNT_W-1:0] add_a, add_b, add_sum;
	logic               req_zero, req_neg, list_full, release_now;
	logic [REQ_W-1:0]   mag;
	logic [NODE_W-1:0]  rd_data;
	list_wr_t           wr;
	list_rd_t           rd;

	assign req_zero  = (req_q == '0);
	assign req_neg   = req_q[REQ_W-1];
	assign mag       = REQ_W'(-req_q);
	assign list_full = (done_count_q == CNT_W'(MAX_NODES));
	// new list length vs group size; 8-bit compare covers a magnitude of 128
	assign release_now = (REQ_W'(add_sum[CNT_W-1:0]) >= mag);

	// shared adder: counter + step, list length + 1, list length - 1
	assign add_sum = add_a + add_b;

	always_comb begin
		state_d = state_q;
		add_a   = counter_q;
		add_b   = COUNT_W'(step_q);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				if (!req_zero && req_neg && !list_full) begin
					add_a = COUNT_W'(done_count_q);
					add_b = COUNT_W'(1);
					if (release_now) begin
						state_d = ST_REL;
					end
				end
			end
			ST_REL: begin
				add_a = COUNT_W'(done_count_q);
				add_b = '1;
				if (done_count_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	assign wr.en   = (state_q == ST_EXEC) && !req_zero && req_neg && !list_full;
	assign wr.addr = done_count_q[NODE_AW-1:0];
	assign wr.data = node_q;
	assign rd.en   = (state_q == ST_REL);
	assign rd.addr = add_sum[NODE_AW-1:0];

	scbr_list u_list (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= STEP_RESET;
			counter_q    <= '0;
			done_count_q <= '0;
			strobe_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= 1'b0;
			if (step_we) begin
				step_q <= step_data;
			end
			unique case (state_q)
				ST_IDLE: ;
				ST_EXEC: begin
					if (req_zero) begin
						strobe_q <= 1'b1;
					end else if (!req_neg) begin
						strobe_q  <= 1'b1;
						counter_q <= add_sum;
					end else if (list_full) begin
						strobe_q <= 1'b1;
					end else begin
						done_count_q <= add_sum[CNT_W-1:0];
					end
				end
				ST_REL: begin
					strobe_q     <= 1'b1;
					done_count_q <= add_sum[CNT_W-1:0];
					if (done_count_q == CNT_W'(1)) begin
						counter_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			node_q <= node_id;
			req_q  <= request_value;
		end
		unique case (state_q)
			ST_IDLE: ;
			ST_EXEC: begin
				from_mem_q <= 1'b0;
				dest_q     <= node_q;
				last_q     <= 1'b1;
				if (req_zero) begin
					count_q  <= '0;
					status_q <= STAT_ZERO;
				end else if (!req_neg) begin
					count_q  <= counter_q;
					status_q <= STAT_REPLY;
				end else begin
					count_q  <= '0;
					status_q <= STAT_OVFL;
				end
			end
			ST_REL: begin
				from_mem_q <= 1'b1;
				count_q    <= counter_q;
				status_q   <= STAT_REPLY;
				last_q     <= (done_count_q == CNT_W'(1));
			end
			default: ;
		endcase
	end

	assign strobe      = strobe_q;
	assign dest_node   = from_mem_q ? rd_data : dest_q;
	assign count_value = count_q;
	assign status      = status_q;
	assign last        = last_q;

endmodule

FILE: rtl/scbr_list.sv
module scbr_list (
	input  logic                     clk,
	input  scbr_pkg::list_wr_t       wr,
	input  scbr_pkg::list_rd_t       rd,
	output logic [scbr_pkg::NODE_W-1:0] rd_data
);
	import scbr_pkg::*;

	logic [NODE_W-1:0] mem [MAX_NODES];
	logic [NODE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
